>>> design/tlmd_pkg.sv
// ----------------------------------------------------------------------------
// tlmd_pkg
// Shared types and constants for the type-length message deframer.
// ----------------------------------------------------------------------------
package tlmd_pkg;

	localparam int unsigned TypeBytes         = 4;
	localparam int unsigned LengthDigitsDflt  = 4;
	localparam int unsigned LengthW           = 16;

	typedef enum logic [1:0] {
		PH_TYPE = 2'd0,
		PH_LEN  = 2'd1,
		PH_PAY  = 2'd2
	} phase_t;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	typedef struct packed {
		logic [2:0]  chars;
		logic [31:0] value;
	} trim_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nibble;
	} hex_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		h.ok     = 1'b1;
		h.nibble = 4'd0;
		if ((c >= 8'h30) && (c <= 8'h39)) begin
			h.nibble = 4'(c - 8'h30);
		end else if ((c >= 8'h61) && (c <= 8'h66)) begin
			h.nibble = 4'(c - 8'h57);
		end else if ((c >= 8'h41) && (c <= 8'h46)) begin
			h.nibble = 4'(c - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	// Strip surrounding whitespace and left-align the remaining characters.
	function automatic trim_t trim_type(input logic [31:0] tb);
		logic [3:0]  ws;
		logic [2:0]  s;
		logic [2:0]  e;
		logic [31:0] m;
		trim_t       t;
		for (int i = 0; i < 4; i++) begin
			ws[i] = is_ws(tb[31 - 8 * i -: 8]);
		end
		s = 3'd4;
		for (int i = 3; i >= 0; i--) begin
			if (!ws[i]) begin
				s = 3'(i);
			end
		end
		e = 3'd0;
		for (int i = 0; i < 4; i++) begin
			if (!ws[i]) begin
				e = 3'(i);
			end
		end
		if (s == 3'd4) begin
			t.chars = 3'd0;
			t.value = 32'd0;
		end else begin
			t.chars = 3'(e - s + 3'd1);
			m       = ~(32'hFFFF_FFFF >> {t.chars, 3'b000});
			t.value = (tb << {s[1:0], 3'b000}) & m;
		end
		return t;
	endfunction

endpackage

>>> design/type_length_message_deframer.sv
// ----------------------------------------------------------------------------
// type_length_message_deframer
// Splits a byte stream into frames of a four-byte type, a hex length field
// and a payload; emits each payload byte tagged with the trimmed type.
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  input     byte_valid / byte_ready      data_byte
//  result    result_valid / result_ready  kind, msg_type, type_chars,
//                                         data_byte_out, last
//
//  One byte per cycle while not stalled; each byte is handled in the cycle
//  it is accepted; any result is in the output register from the next cycle.
//  byte_ready is high while the output register is empty or being emptied.
//  A stalled result holds the input side; bytes are never dropped.
//  Reset returns the parser to the type field with no result pending.
// ----------------------------------------------------------------------------
module type_length_message_deframer
	import tlmd_pkg::*;
#(
	parameter int unsigned LENGTH_DIGITS = LengthDigitsDflt
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_ready,
	input  logic [7:0]           data_byte,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [1:0]           kind,
	output logic [31:0]          msg_type,
	output logic [2:0]           type_chars,
	output logic [7:0]           data_byte_out,
	output logic                 last
);

	localparam int unsigned PosW = $clog2(LENGTH_DIGITS + 4);

	phase_t             phase_q, phase_d;
	logic [PosW-1:0]    pos_q, pos_d;
	logic [31:0]        type_bytes_q, type_bytes_d;
	logic [LengthW-1:0] len_q, len_d;
	logic               bad_q, bad_d;
	logic [LengthW-1:0] rem_q, rem_d;
	logic [31:0]        tv_q, tv_d;
	logic [2:0]         tc_q, tc_d;

	logic               accept;
	logic               emit;
	logic [1:0]         kind_d;
	logic [31:0]        msg_type_d;
	logic [2:0]         type_chars_d;
	logic [7:0]         data_out_d;
	logic               last_d;

	hex_t               hx;
	trim_t              tr;
	logic               bad_fin;
	logic [LengthW-1:0] len_fin;
	logic [LengthW-1:0] rem_dec;

	assign byte_ready = !result_valid || result_ready;
	assign accept     = byte_valid && byte_ready;

	assign hx      = hex_digit(data_byte);
	assign tr      = trim_type(type_bytes_q);
	assign rem_dec = rem_q - LengthW'(1);

	always_comb begin
		bad_fin = bad_q;
		len_fin = len_q;
		if (!bad_q) begin
			if (!hx.ok || (len_q[LengthW-1 -: 4] != 4'd0)) begin
				bad_fin = 1'b1;
			end else begin
				len_fin = {len_q[LengthW-5:0], hx.nibble};
			end
		end
	end

	always_comb begin
		phase_d      = phase_q;
		pos_d        = pos_q;
		type_bytes_d = type_bytes_q;
		len_d        = len_q;
		bad_d        = bad_q;
		rem_d        = rem_q;
		tv_d         = tv_q;
		tc_d         = tc_q;
		emit         = 1'b0;
		kind_d       = KIND_PAYLOAD;
		msg_type_d   = 32'd0;
		type_chars_d = 3'd0;
		data_out_d   = 8'd0;
		last_d       = 1'b0;
		unique case (phase_q)
			PH_PAY: begin
				rem_d        = rem_dec;
				emit         = 1'b1;
				kind_d       = KIND_PAYLOAD;
				msg_type_d   = tv_q;
				type_chars_d = tc_q;
				data_out_d   = data_byte;
				last_d       = (rem_dec == '0);
				if (rem_dec == '0) begin
					phase_d = PH_TYPE;
					pos_d   = '0;
				end
			end
			PH_LEN: begin
				len_d = len_fin;
				bad_d = bad_fin;
				pos_d = pos_q + PosW'(1);
				if (pos_q == PosW'(LENGTH_DIGITS - 1)) begin
					phase_d = PH_TYPE;
					pos_d   = '0;
					if (tr.chars == 3'd0) begin
						emit = 1'b0;
					end else if (bad_fin) begin
						emit   = 1'b1;
						kind_d = KIND_ERROR;
						last_d = 1'b1;
					end else if (len_fin == '0) begin
						emit         = 1'b1;
						kind_d       = KIND_EMPTY;
						msg_type_d   = tr.value;
						type_chars_d = tr.chars;
						last_d       = 1'b1;
					end else begin
						phase_d = PH_PAY;
						rem_d   = len_fin;
						tv_d    = tr.value;
						tc_d    = tr.chars;
					end
				end
			end
			default: begin
				phase_d      = PH_TYPE;
				type_bytes_d = {type_bytes_q[23:0], data_byte};
				pos_d        = PosW'(pos_q[1:0] + 2'd1);
				if (pos_q[1:0] == 2'd3) begin
					phase_d = PH_LEN;
					pos_d   = '0;
					len_d   = '0;
					bad_d   = 1'b0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			pos_q   <= '0;
			len_q   <= '0;
			bad_q   <= 1'b0;
			rem_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			bad_q   <= bad_d;
			rem_q   <= rem_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_bytes_q <= type_bytes_d;
			tv_q         <= tv_d;
			tc_q         <= tc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (accept && emit) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			kind          <= kind_d;
			msg_type      <= msg_type_d;
			type_chars    <= type_chars_d;
			data_byte_out <= data_out_d;
			last          <= last_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_pay_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAY |-> rem_q != '0)
		else $error("payload phase with nothing left to receive");

	a_pay_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_PAY |=> result_valid && kind == KIND_PAYLOAD)
		else $error("payload byte gave no result");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_ERROR |->
			last && type_chars == 3'd0 && msg_type == 32'd0 && data_byte_out == 8'd0)
		else $error("malformed header-error result");

	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_EMPTY |->
			last && type_chars != 3'd0 && data_byte_out == 8'd0)
		else $error("malformed empty-message result");
`endif

endmodule
